// ----- rtl/core/scp_pkg.sv -----
package scp_pkg;

	localparam int FRAME_DEPTH = 8;
	// bytes that carry meaning: a motor frame is the longest decoded frame
	localparam int MOTOR_LEN = 7;
	localparam int IDX_W = $clog2(MOTOR_LEN);

	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_UP_M = 8'h4D;
	localparam logic [7:0] CH_UP_N = 8'h4E;
	localparam logic [7:0] CH_UP_P = 8'h50;
	localparam logic [7:0] CH_UP_F = 8'h46;
	localparam logic [7:0] CH_UP_B = 8'h42;
	localparam logic [7:0] CH_UP_S = 8'h53;
	localparam logic [7:0] CH_LO_N = 8'h6E;
	localparam logic [7:0] CH_LO_F = 8'h66;
	localparam logic [7:0] CH_LO_I = 8'h69;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_TWO = 8'h32;
	localparam logic [7:0] CH_NINE = 8'h39;

	localparam logic [3:0] EV_NONE = 4'd0;
	localparam logic [3:0] EV_UNLOCK0 = 4'd1;
	localparam logic [3:0] EV_SHOOTER_ON = 4'd4;
	localparam logic [3:0] EV_SHOOTER_OFF = 4'd5;
	localparam logic [3:0] EV_SHOOT = 4'd6;
	localparam logic [3:0] EV_MOTOR = 4'd7;
	localparam logic [3:0] EV_MOTOR_ERR = 4'd8;

	localparam logic [1:0] DIR_STOP = 2'd0;
	localparam logic [1:0] DIR_FWD = 2'd1;
	localparam logic [1:0] DIR_BACK = 2'd2;

	localparam logic [6:0] THR_FULL = 7'd100;

	typedef logic [7:0] byte_t;
	typedef byte_t [MOTOR_LEN-1:0] frame_t;

	typedef struct packed {
		logic [1:0] dir;
		logic signed [7:0] angle;
		logic [6:0] throttle;
	} held_t;

	function automatic logic is_digit(input byte_t c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// ascii digits 0x30..0x39 carry their value in the low nibble
	function automatic logic [6:0] two_digit(input byte_t hi, input byte_t lo);
		logic [6:0] h;
		logic [6:0] l;
		h = {3'b000, hi[3:0]};
		l = {3'b000, lo[3:0]};
		return (h << 3) + (h << 1) + l;
	endfunction

endpackage

// ----- rtl/core/scp_char_if.sv -----
interface scp_char_if;
	logic valid;
	logic ready;
	logic [7:0] rx_char;

	modport source(output valid, output rx_char, input ready);
	modport sink(input valid, input rx_char, output ready);
endinterface

// ----- rtl/core/scp_event_if.sv -----
interface scp_event_if;
	logic valid;
	logic ready;
	logic [3:0] event_code;
	logic [1:0] direction;
	logic signed [7:0] angle;
	logic [6:0] throttle;

	modport source(output valid, output event_code, output direction, output angle,
		output throttle, input ready);
	modport sink(input valid, input event_code, input direction, input angle,
		input throttle, output ready);
endinterface

// ----- rtl/core/scp_decode.sv -----
module scp_decode #(
	parameter int LEN_W = 4
) (
	input scp_pkg::frame_t frame,
	input logic [LEN_W-1:0] len,
	input scp_pkg::held_t held,
	output logic [3:0] event_code,
	output scp_pkg::held_t held_next
);

	logic err;
	logic neg;
	logic signed [7:0] ang_abs;

	assign ang_abs = {1'b0, scp_pkg::two_digit(frame[3], frame[4])};

	always_comb begin
		held_next = held;
		event_code = scp_pkg::EV_NONE;
		err = 1'b0;
		neg = 1'b0;
		if (len == LEN_W'(2)) begin
			if (frame[1] >= scp_pkg::CH_ZERO && frame[1] <= scp_pkg::CH_TWO) begin
				event_code = scp_pkg::EV_UNLOCK0 + {2'b00, frame[1][1:0]};
			end
		end else if (len == LEN_W'(3)) begin
			case (frame[2])
				scp_pkg::CH_LO_N: event_code = scp_pkg::EV_SHOOTER_ON;
				scp_pkg::CH_LO_F: event_code = scp_pkg::EV_SHOOTER_OFF;
				scp_pkg::CH_LO_I: event_code = scp_pkg::EV_SHOOT;
				default: event_code = scp_pkg::EV_NONE;
			endcase
		end else if (len == LEN_W'(scp_pkg::MOTOR_LEN)) begin
			// direction field only counts when the frame opens with 'M'
			if (frame[0] == scp_pkg::CH_UP_M) begin
				unique case (frame[1])
					scp_pkg::CH_UP_F: held_next.dir = scp_pkg::DIR_FWD;
					scp_pkg::CH_UP_B: held_next.dir = scp_pkg::DIR_BACK;
					scp_pkg::CH_UP_S: held_next.dir = scp_pkg::DIR_STOP;
					default: err = 1'b1;
				endcase
			end
			if (frame[2] == scp_pkg::CH_UP_N) begin
				neg = 1'b1;
			end else if (frame[2] != scp_pkg::CH_UP_P) begin
				err = 1'b1;
			end
			if (scp_pkg::is_digit(frame[3]) && scp_pkg::is_digit(frame[4])) begin
				held_next.angle = neg ? -ang_abs : ang_abs;
			end else begin
				err = 1'b1;
			end
			if (frame[5] == scp_pkg::CH_UP_M) begin
				held_next.throttle = scp_pkg::THR_FULL;
			end else if (scp_pkg::is_digit(frame[5]) && scp_pkg::is_digit(frame[6])) begin
				held_next.throttle = scp_pkg::two_digit(frame[5], frame[6]);
			end else begin
				err = 1'b1;
			end
			event_code = err ? scp_pkg::EV_MOTOR_ERR : scp_pkg::EV_MOTOR;
		end
	end

endmodule

// ----- rtl/core/serial_command_parser_top.sv -----
// channel | dir | payload                                  | beat when
// rx      | in  | rx_char[7:0]                             | rx.valid & rx.ready
// evt     | out | event_code, direction, angle, throttle   | evt.valid & evt.ready
//
// one character per cycle unless rx stalls; a character is held in the input
// register, folded into the frame state there; a ';' loads the result register.
// a ';' passes through the input register and then the result register to evt.valid.
// arst_n clears the frame length, held motor values and both valid flags.
// rx stalls only when a ';' waits in the input register behind an untaken result.
module serial_command_parser_top #(
	parameter int FRAME_DEPTH = scp_pkg::FRAME_DEPTH
) (
	input logic clk,
	input logic arst_n,
	scp_char_if.sink rx,
	scp_event_if.source evt
);

	localparam int LEN_W = $clog2(FRAME_DEPTH + 1);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(FRAME_DEPTH);
	localparam logic [LEN_W-1:0] LEN_STORE = LEN_W'(scp_pkg::MOTOR_LEN);

	logic valid_s1;
	scp_pkg::byte_t char_s1;
	scp_pkg::frame_t frame_q;
	logic [LEN_W-1:0] len_q;
	scp_pkg::held_t held_q;
	scp_pkg::held_t held_next;
	logic [3:0] code_next;

	logic out_valid_q;
	logic [3:0] out_code_q;
	scp_pkg::held_t out_held_q;

	logic is_semi;
	logic is_eol;
	logic s1_fire;
	logic store;

	assign is_semi = (char_s1 == scp_pkg::CH_SEMI);
	assign is_eol = (char_s1 == scp_pkg::CH_CR) || (char_s1 == scp_pkg::CH_LF);
	assign s1_fire = valid_s1 && (!is_semi || !out_valid_q || evt.ready);
	assign rx.ready = !valid_s1 || s1_fire;
	assign store = s1_fire && !is_semi && !is_eol;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			char_s1 <= rx.rx_char;
		end
	end

	// bytes past the motor frame length never reach the decoder
	always_ff @(posedge clk) begin
		if (store && len_q < LEN_STORE) begin
			frame_q[len_q[scp_pkg::IDX_W-1:0]] <= char_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			held_q <= '{dir: scp_pkg::DIR_STOP, angle: 8'sd0, throttle: 7'd0};
		end else if (s1_fire) begin
			if (is_semi) begin
				len_q <= '0;
				held_q <= held_next;
			end else if (!is_eol && len_q < LEN_MAX) begin
				len_q <= len_q + LEN_W'(1);
			end
		end
	end

	scp_decode #(
		.LEN_W(LEN_W)
	) u_decode (
		.frame(frame_q),
		.len(len_q),
		.held(held_q),
		.event_code(code_next),
		.held_next(held_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && is_semi) begin
			out_valid_q <= 1'b1;
		end else if (evt.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && is_semi) begin
			out_code_q <= code_next;
			out_held_q <= held_next;
		end
	end

	assign evt.valid = out_valid_q;
	assign evt.event_code = out_code_q;
	assign evt.direction = out_held_q.dir;
	assign evt.angle = out_held_q.angle;
	assign evt.throttle = out_held_q.throttle;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_MAX)
		else $error("frame length beyond buffer depth");

	a_len_clear: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && is_semi |=> len_q == '0)
		else $error("frame length not cleared after terminator");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && is_semi && out_valid_q |-> evt.ready)
		else $error("result overwritten before taken");

	a_motor_range: assert property (@(posedge clk) disable iff (!arst_n)
		evt.valid |-> (evt.angle >= -8'sd99) && (evt.angle <= 8'sd99)
			&& (evt.throttle <= scp_pkg::THR_FULL) && (evt.direction != 2'd3))
		else $error("held motor value out of range");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		evt.valid |-> evt.event_code <= scp_pkg::EV_MOTOR_ERR)
		else $error("event code out of range");

endmodule

// ----- tb/scp_event_checker.sv -----
`timescale 1ns / 100ps

module scp_event_checker
	import scp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	scp_char_if rx,
	scp_event_if evt,
	output int fails,
	output int pending
);

	typedef struct {
		logic [3:0] code;
		logic [1:0] dir;
		logic signed [7:0] angle;
		logic [6:0] throttle;
	} parsed_event_t;

	byte_t frame_q [FRAME_DEPTH];
	int frame_len;
	logic [1:0] hold_dir;
	logic signed [7:0] hold_angle;
	logic [6:0] hold_thr;
	parsed_event_t expected_events [$];
	int error_count = 0;

	assign fails = error_count;

	task automatic report_mismatch(input string msg);
		$display("%0t ns  event mismatch: %s", $time, msg);
		error_count++;
	endtask

	function automatic bit numeral(input byte_t c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// decodes the buffered frame and updates the held motor values
	task automatic decode_frame(output logic [3:0] code);
		bit bad;
		bit neg;
		int mag;
		bad = 1'b0;
		neg = 1'b0;
		code = EV_NONE;
		case (frame_len)
			2: begin
				if (frame_q[1] >= CH_ZERO && frame_q[1] <= CH_TWO)
					code = EV_UNLOCK0 + 4'(frame_q[1] - CH_ZERO);
			end
			3: begin
				case (frame_q[2])
					CH_LO_N: code = EV_SHOOTER_ON;
					CH_LO_F: code = EV_SHOOTER_OFF;
					CH_LO_I: code = EV_SHOOT;
					default: code = EV_NONE;
				endcase
			end
			MOTOR_LEN: begin
				// direction letter only counts behind a leading M
				if (frame_q[0] == CH_UP_M) begin
					case (frame_q[1])
						CH_UP_F: hold_dir = DIR_FWD;
						CH_UP_B: hold_dir = DIR_BACK;
						CH_UP_S: hold_dir = DIR_STOP;
						default: bad = 1'b1;
					endcase
				end
				if (frame_q[2] == CH_UP_N)
					neg = 1'b1;
				else if (frame_q[2] != CH_UP_P)
					bad = 1'b1;
				if (numeral(frame_q[3]) && numeral(frame_q[4])) begin
					mag = int'(frame_q[3] - CH_ZERO) * 10 + int'(frame_q[4] - CH_ZERO);
					hold_angle = 8'(neg ? -mag : mag);
				end else begin
					bad = 1'b1;
				end
				if (frame_q[5] == CH_UP_M)
					hold_thr = THR_FULL;
				else if (numeral(frame_q[5]) && numeral(frame_q[6]))
					hold_thr = 7'(int'(frame_q[5] - CH_ZERO) * 10 + int'(frame_q[6] - CH_ZERO));
				else
					bad = 1'b1;
				code = bad ? EV_MOTOR_ERR : EV_MOTOR;
			end
			default: code = EV_NONE;
		endcase
	endtask

	task automatic accept_char(input byte_t c);
		parsed_event_t e;
		if (c == CH_CR || c == CH_LF)
			return;
		if (c != CH_SEMI) begin
			// length saturates, extra bytes are dropped
			if (frame_len < FRAME_DEPTH) begin
				frame_q[frame_len] = c;
				frame_len++;
			end
			return;
		end
		decode_frame(e.code);
		e.dir = hold_dir;
		e.angle = hold_angle;
		e.throttle = hold_thr;
		expected_events.push_back(e);
		foreach (frame_q[i])
			frame_q[i] = '0;
		frame_len = 0;
	endtask

	task automatic check_event();
		parsed_event_t want;
		if (expected_events.size() == 0) begin
			report_mismatch($sformatf("unexpected beat, event_code %0d", evt.event_code));
			return;
		end
		want = expected_events.pop_front();
		if (evt.event_code !== want.code)
			report_mismatch($sformatf("event_code got %0d want %0d", evt.event_code, want.code));
		if (evt.direction !== want.dir)
			report_mismatch($sformatf("direction got %0d want %0d", evt.direction, want.dir));
		if (evt.angle !== want.angle)
			report_mismatch($sformatf("angle got %0d want %0d", evt.angle, want.angle));
		if (evt.throttle !== want.throttle)
			report_mismatch($sformatf("throttle got %0d want %0d", evt.throttle, want.throttle));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (frame_q[i])
				frame_q[i] = '0;
			frame_len = 0;
			hold_dir = DIR_STOP;
			hold_angle = '0;
			hold_thr = '0;
			expected_events.delete();
		end else begin
			if (rx.valid === 1'b1 && rx.ready === 1'b1)
				accept_char(rx.rx_char);
			if (evt.valid === 1'b1 && evt.ready === 1'b1)
				check_event();
		end
		pending <= expected_events.size();
	end

endmodule

// ----- tb/tb_serial_command_parser_top.sv -----
`timescale 1ns / 100ps

module tb_serial_command_parser_top;
	import scp_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	int sent = 0;
	int fails;
	int pending;
	logic steady;
	bit holdoff_done = 1'b0;
	byte_t burst [$];

	scp_char_if char_bus();
	scp_event_if event_bus();

	serial_command_parser_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.rx(char_bus),
		.evt(event_bus)
	);

	scp_event_checker u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.rx(char_bus),
		.evt(event_bus),
		.fails(fails),
		.pending(pending)
	);

	always #6 clk = ~clk;

	// window with no idling on either side
	assign steady = (sent >= 350) && (sent < 500);

	function automatic byte_t any_byte();
		return 8'($urandom_range(255));
	endfunction

	function automatic byte_t digit_or_junk(input int junk_pct);
		if ($urandom_range(99) < junk_pct)
			return any_byte();
		return CH_ZERO + 8'($urandom_range(9));
	endfunction

	task automatic send_char(input byte_t c);
		while (!steady && $urandom_range(99) < 9) begin
			char_bus.valid <= 1'b0;
			@(negedge clk);
		end
		char_bus.valid <= 1'b1;
		char_bus.rx_char <= c;
		@(posedge clk);
		while (char_bus.ready !== 1'b1)
			@(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	// sends the staged bytes followed by the terminator
	task automatic send_frame();
		burst.push_back(CH_SEMI);
		foreach (burst[i])
			send_char(burst[i]);
		burst.delete();
	endtask

	task automatic build_random_frame();
		int kind;
		int n;
		byte_t pick;
		kind = $urandom_range(99);
		if (kind < 15) begin
			burst.push_back(any_byte());
			pick = CH_ZERO + 8'($urandom_range(2));
			burst.push_back(($urandom_range(99) < 80) ? pick : any_byte());
		end else if (kind < 30) begin
			burst.push_back(any_byte());
			burst.push_back(any_byte());
			case ($urandom_range(3))
				0: pick = CH_LO_N;
				1: pick = CH_LO_F;
				2: pick = CH_LO_I;
				default: pick = any_byte();
			endcase
			burst.push_back(pick);
		end else if (kind < 75) begin
			burst.push_back(($urandom_range(99) < 90) ? CH_UP_M : any_byte());
			case ($urandom_range(6))
				0, 1: pick = CH_UP_F;
				2, 3: pick = CH_UP_B;
				4, 5: pick = CH_UP_S;
				default: pick = any_byte();
			endcase
			burst.push_back(pick);
			case ($urandom_range(6))
				0, 1, 2: pick = CH_UP_N;
				3, 4, 5: pick = CH_UP_P;
				default: pick = any_byte();
			endcase
			burst.push_back(pick);
			burst.push_back(digit_or_junk(10));
			burst.push_back(digit_or_junk(10));
			n = $urandom_range(9);
			burst.push_back((n < 3) ? CH_UP_M : digit_or_junk((n == 9) ? 100 : 0));
			burst.push_back(digit_or_junk(10));
		end else begin
			n = (kind < 90) ? $urandom_range(11) : $urandom_range(1) * 4 + $urandom_range(2);
			repeat (n)
				burst.push_back(any_byte());
		end
		// stray line endings inside a frame
		if ($urandom_range(99) < 6) begin
			pick = $urandom_range(1) ? CH_CR : CH_LF;
			burst.insert($urandom_range(burst.size()), pick);
		end
	endtask

	// receiver: random stalls plus one long hold-off to back up the pipe
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (sent >= 200 && !holdoff_done) begin
				holdoff_done = 1'b1;
				event_bus.ready <= 1'b0;
				repeat (300)
					@(negedge clk);
			end else begin
				event_bus.ready <= steady || ($urandom_range(99) >= 9);
			end
		end
	end

	initial begin
		#(5_000_000);
		$display("[serial_command_parser_top] ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		char_bus.valid = 1'b0;
		char_bus.rx_char = '0;
		event_bus.ready = 1'b0;
		repeat (6)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// motor frame at the extremes: back, -99, full throttle
		burst = {CH_UP_M, CH_UP_B, CH_UP_N, CH_NINE, CH_NINE, CH_UP_M, "x"};
		send_frame();
		send_char(CH_CR);
		send_char(CH_LF);
		burst = {"U", CH_TWO};
		send_frame();
		burst = {"a", "b", CH_LO_I};
		send_frame();
		// overflow: nine bytes into an eight deep frame
		burst = {8'h00, 8'hFF, CH_UP_M, CH_UP_F, CH_UP_P, CH_NINE, CH_NINE, CH_NINE, CH_NINE};
		send_frame();

		while (sent < 700) begin
			build_random_frame();
			send_frame();
		end
		char_bus.valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
		if (fails == 0)
			$display("[serial_command_parser_top] OK");
		else
			$display("[serial_command_parser_top] ERROR");
		$finish;
	end

endmodule
